>>> design/bsfe_pkg.sv
package bsfe_pkg;

  localparam int unsigned NBITS     = 1024;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned NWORDS    = NBITS / WORD_BITS;
  localparam int unsigned WADDR_W   = $clog2(NWORDS);
  localparam int unsigned BPOS_W    = $clog2(WORD_BITS);
  localparam int unsigned REQ_W     = 4;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned POP_W     = $clog2(WORD_BITS + 1);

  localparam logic [REQ_W-1:0] REQ_SET         = 4'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR       = 4'd1;
  localparam logic [REQ_W-1:0] REQ_FLIP        = 4'd2;
  localparam logic [REQ_W-1:0] REQ_TEST        = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SET_ALL     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR_ALL   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_INVERT_ALL  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_FIND_SET    = 4'd7;
  localparam logic [REQ_W-1:0] REQ_FIND_CLEAR  = 4'd8;
  localparam logic [REQ_W-1:0] REQ_COUNT_SET   = 4'd9;
  localparam logic [REQ_W-1:0] REQ_COUNT_CLEAR = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] bit_pos;
  } req_t;

  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] population;
  } res_t;

endpackage

>>> design/bsfe_ram.sv
module bsfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bitmap_set_clear_find_engine.sv
// Channel  | Signals                    | Beat taken when
// ---------+----------------------------+---------------------------
// request  | start, busy, req_i         | start high and busy low
// result   | res_valid_o, res_o         | every cycle res_valid_o is high
// config   | cfg_we_i, cfg_wdata_i      | every cycle cfg_we_i is high
//
// The bitmap lives in a 32 by 32 memory that is read, modified and written back one word a cycle.
// Single-bit requests and unknown codes hold busy for a walk of one word; whole-map operations and counts
// hold it for a walk of all 32 words. A search walks from the word that holds its start to the last word.
// The result is registered in the flush state and shows when busy is already low again.
// After reset a pass clears the whole store; after each configuration write a pass clears the inactive
// bits.
// The receiver cannot stall; a new request may be taken in the cycle a result is shown.
module bitmap_set_clear_find_engine
  import bsfe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  function automatic logic [WORD_BITS-1:0] act_mask(input logic [WADDR_W-1:0] addr,
                                                    input logic [CNT_W-1:0]   limit);
    logic [CNT_W-BPOS_W-1:0] full;
    logic [BPOS_W-1:0]       rem;
    full = limit[CNT_W-1:BPOS_W];
    rem  = limit[BPOS_W-1:0];
    if ((CNT_W-BPOS_W)'(addr) < full) begin
      return '1;
    end else if ((CNT_W-BPOS_W)'(addr) == full) begin
      return (WORD_BITS'(1) << rem) - WORD_BITS'(1);
    end else begin
      return '0;
    end
  endfunction

  function automatic logic [POP_W-1:0] pop_word(input logic [WORD_BITS-1:0] w);
    logic [POP_W-1:0] sum;
    logic [3:0]       byte_cnt;
    sum = '0;
    for (int b = 0; b < WORD_BITS / 8; b++) begin
      byte_cnt = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt = byte_cnt + 4'(w[8*b+i]);
      end
      sum = sum + POP_W'(byte_cnt);
    end
    return sum;
  endfunction

  function automatic logic [BPOS_W-1:0] lsb_index(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] onehot;
    logic [BPOS_W-1:0]    idx;
    onehot = w & (~w + WORD_BITS'(1));
    idx    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | BPOS_W'(i);
      end
    end
    return idx;
  endfunction

  state_e               state_q, state_d;
  logic                 sweep_q, sweep_d;
  logic [REQ_W-1:0]     op_q, op_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [WADDR_W-1:0]   ptr_q, ptr_d;
  logic [WADDR_W-1:0]   last_q, last_d;
  logic                 s1_vld_q;
  logic [WADDR_W-1:0]   s1_addr_q;
  logic                 fnd_q, fnd_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 bv_q, bv_d;
  logic [CNT_W-1:0]     active_q, active_d;
  logic [CNT_W-1:0]     lim_q, lim_d;
  res_t                 res_q, res_d;
  logic                 res_vld_q, res_vld_d;

  logic                 accept;
  logic                 finish;
  logic [CNT_W-1:0]     eff_n;
  logic [CNT_W-1:0]     new_eff;
  logic [CNT_W-1:0]     limit;
  logic [WORD_BITS-1:0] word_act;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;
  logic                 rd_en;
  logic [BPOS_W-1:0]    bidx;
  logic [WADDR_W-1:0]   widx;
  logic [WORD_BITS-1:0] bit_m;
  logic                 in_rng;
  logic [WORD_BITS-1:0] start_m;
  logic [WORD_BITS-1:0] cand;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign finish   = (state_q == ST_FLUSH);
  assign eff_n    = (active_q > CNT_W'(NBITS)) ? CNT_W'(NBITS) : active_q;
  assign new_eff  = (cfg_wdata_i > CNT_W'(NBITS)) ? CNT_W'(NBITS) : cfg_wdata_i;
  assign limit    = sweep_q ? lim_q : eff_n;
  assign word_act = act_mask(s1_addr_q, limit);
  assign bidx     = idx_q[BPOS_W-1:0];
  assign widx     = idx_q[BPOS_W +: WADDR_W];
  assign bit_m    = WORD_BITS'(1) << bidx;
  assign in_rng   = (CNT_W'(idx_q) < eff_n);
  assign start_m  = (s1_addr_q == widx) ? ('1 << bidx) : '1;
  assign rd_en    = (state_q == ST_WALK);

  bsfe_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NWORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_addr_q),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ptr_q == last_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      state_d = ST_WALK;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (s1_vld_q) begin
      if (sweep_q) begin
        we    = 1'b1;
        wdata = rdata & word_act;
      end else begin
        unique case (op_q)
          REQ_SET: begin
            we    = 1'b1;
            wdata = in_rng ? (rdata | bit_m) : rdata;
          end
          REQ_CLEAR: begin
            we    = 1'b1;
            wdata = in_rng ? (rdata & ~bit_m) : rdata;
          end
          REQ_FLIP: begin
            we    = 1'b1;
            wdata = in_rng ? (rdata ^ bit_m) : rdata;
          end
          REQ_SET_ALL: begin
            we    = 1'b1;
            wdata = word_act;
          end
          REQ_CLEAR_ALL: begin
            we    = 1'b1;
            wdata = '0;
          end
          REQ_INVERT_ALL: begin
            we    = 1'b1;
            wdata = ~rdata & word_act;
          end
          default: begin
            we    = 1'b0;
            wdata = rdata;
          end
        endcase
      end
    end
  end

  always_comb begin
    sweep_d   = sweep_q;
    op_d      = op_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    last_d    = last_q;
    fnd_d     = fnd_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    bv_d      = bv_q;
    active_d  = active_q;
    lim_d     = lim_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    cand      = (op_q == REQ_FIND_SET) ? rdata : ~rdata;
    cand      = cand & word_act & start_m;

    if (rd_en) begin
      ptr_d = ptr_q + WADDR_W'(1);
    end

    if (s1_vld_q && !sweep_q) begin
      unique case (op_q)
        REQ_TEST: begin
          bv_d = rdata[bidx] & in_rng;
        end
        REQ_FIND_SET, REQ_FIND_CLEAR: begin
          if (!fnd_q && (cand != '0)) begin
            fnd_d = 1'b1;
            pos_d = {s1_addr_q, lsb_index(cand)};
          end
        end
        REQ_COUNT_SET, REQ_COUNT_CLEAR: begin
          cnt_d = cnt_q + CNT_W'(pop_word(rdata & word_act));
        end
        default: begin
          bv_d = bv_q;
        end
      endcase
    end

    if (finish && !sweep_q) begin
      res_vld_d = 1'b1;
      res_d     = '0;
      unique case (op_q)
        REQ_TEST: begin
          res_d.bit_value = bv_d;
        end
        REQ_FIND_SET, REQ_FIND_CLEAR: begin
          res_d.found    = fnd_d;
          res_d.position = pos_d;
        end
        REQ_COUNT_SET: begin
          res_d.population = cnt_d;
        end
        REQ_COUNT_CLEAR: begin
          res_d.population = eff_n - cnt_d;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end

    if (accept) begin
      sweep_d = 1'b0;
      op_d    = req_i.req_type;
      idx_d   = req_i.bit_pos;
      fnd_d   = 1'b0;
      pos_d   = '0;
      cnt_d   = '0;
      bv_d    = 1'b0;
      unique case (req_i.req_type)
        REQ_SET, REQ_CLEAR, REQ_FLIP, REQ_TEST: begin
          ptr_d  = req_i.bit_pos[BPOS_W +: WADDR_W];
          last_d = req_i.bit_pos[BPOS_W +: WADDR_W];
        end
        REQ_FIND_SET, REQ_FIND_CLEAR: begin
          ptr_d  = req_i.bit_pos[BPOS_W +: WADDR_W];
          last_d = WADDR_W'(NWORDS - 1);
        end
        REQ_SET_ALL, REQ_CLEAR_ALL, REQ_INVERT_ALL, REQ_COUNT_SET, REQ_COUNT_CLEAR: begin
          ptr_d  = '0;
          last_d = WADDR_W'(NWORDS - 1);
        end
        default: begin
          ptr_d  = '0;
          last_d = '0;
        end
      endcase
    end

    if (cfg_we_i) begin
      active_d = cfg_wdata_i;
      if (sweep_q && busy && (lim_q < new_eff)) begin
        lim_d = lim_q;
      end else begin
        lim_d = new_eff;
      end
      sweep_d = 1'b1;
      ptr_d   = '0;
      last_d  = WADDR_W'(NWORDS - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_WALK;
      sweep_q   <= 1'b1;
      ptr_q     <= '0;
      last_q    <= WADDR_W'(NWORDS - 1);
      s1_vld_q  <= 1'b0;
      active_q  <= CNT_W'(NBITS);
      lim_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      ptr_q     <= ptr_d;
      last_q    <= last_d;
      s1_vld_q  <= rd_en;
      active_q  <= active_d;
      lim_q     <= lim_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    idx_q     <= idx_d;
    s1_addr_q <= ptr_q;
    fnd_q     <= fnd_d;
    pos_q     <= pos_d;
    cnt_q     <= cnt_d;
    bv_q      <= bv_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
